// ----- design/bft_pkg.sv -----
package bft_pkg;

  localparam int unsigned DEF_BUCKET_COUNT = 64;
  localparam int unsigned DEF_WAY_COUNT    = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_SWEEP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EXEC,
    S_SWEEP,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } key_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] expiry;
  } age_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] expire_time;
    logic [31:0] now_time;
  } in_beat_t;

  typedef struct packed {
    logic       found;
    logic [7:0] entry_index;
    logic [1:0] status;
    logic [8:0] removed_count;
    logic [8:0] live_count;
  } out_beat_t;

endpackage

// ----- design/bft_hash.sv -----
module bft_hash import bft_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = DEF_BUCKET_COUNT,
  localparam int unsigned RW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  key_t          key_i,
  output logic          done_o,
  output logic [RW-1:0] bucket_o
);

  logic [31:0] x0, x1, fold;

  // symmetric xor fold of the key
  assign x0   = key_i.src_ip ^ key_i.dst_ip ^ {16'd0, key_i.sport} ^ {16'd0, key_i.dport};
  assign x1   = x0 ^ (x0 >> 16);
  assign fold = x1 ^ (x1 >> 8);

  if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0) begin : g_mask
    assign done_o   = start_i;
    assign bucket_o = RW'(fold & 32'(BUCKET_COUNT - 1));
  end else begin : g_recip
    // remainder by reciprocal multiplication, quotient then remainder
    localparam int unsigned SH = 32 + RW;
    localparam logic [32:0] MAGIC =
      33'(((64'd1 << SH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));

    logic        mul_q, mul_d;
    logic        rem_q, rem_d;
    logic [31:0] x_q, x_d;
    logic [31:0] quo_q, quo_d;
    logic [64:0] prod;
    logic [31:0] rem;

    assign prod     = 65'(x_q) * 65'(MAGIC);
    assign rem      = x_q - quo_q * 32'(BUCKET_COUNT);
    assign done_o   = rem_q;
    assign bucket_o = rem[RW-1:0];

    always_comb begin
      mul_d = start_i;
      rem_d = mul_q;
      x_d   = start_i ? fold : x_q;
      quo_d = mul_q ? 32'(prod >> SH) : quo_q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_q <= 1'b0;
        rem_q <= 1'b0;
      end else begin
        mul_q <= mul_d;
        rem_q <= rem_d;
      end
    end

    always_ff @(posedge clk_i) begin
      x_q   <= x_d;
      quo_q <= quo_d;
    end
  end

endmodule

// ----- design/bft_key_store.sv -----
module bft_key_store import bft_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int unsigned WAY_COUNT    = DEF_WAY_COUNT,
  localparam int unsigned RW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [RW-1:0]        rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [RW-1:0]        wr_addr_i,
  input  logic [WAY_COUNT-1:0] wr_mask_i,
  input  key_t                 wr_key_i,
  input  key_t                 probe_key_i,
  output logic [WAY_COUNT-1:0] match_o
);

  key_t key_mem_q [BUCKET_COUNT][WAY_COUNT];
  key_t rd_row_q  [WAY_COUNT];
  key_t rev_key;

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (wr_en_i && wr_mask_i[w]) begin
        key_mem_q[wr_addr_i][w] <= wr_key_i;
      end
      if (rd_en_i) begin
        rd_row_q[w] <= key_mem_q[rd_addr_i][w];
      end
    end
  end

  // reverse direction of the probe key
  always_comb begin
    rev_key.src_ip = probe_key_i.dst_ip;
    rev_key.dst_ip = probe_key_i.src_ip;
    rev_key.sport  = probe_key_i.dport;
    rev_key.dport  = probe_key_i.sport;
  end

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      match_o[w] = (rd_row_q[w] == probe_key_i) || (rd_row_q[w] == rev_key);
    end
  end

endmodule

// ----- design/bft_age_store.sv -----
module bft_age_store import bft_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int unsigned WAY_COUNT    = DEF_WAY_COUNT,
  localparam int unsigned RW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [RW-1:0]        rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [RW-1:0]        wr_addr_i,
  input  logic [WAY_COUNT-1:0] wr_mask_i,
  input  age_t                 wr_entry_i,
  input  logic [31:0]          now_i,
  output logic [WAY_COUNT-1:0] valid_o,
  output logic [WAY_COUNT-1:0] expired_o
);

  age_t age_mem_q [BUCKET_COUNT][WAY_COUNT];
  age_t rd_row_q  [WAY_COUNT];

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (wr_en_i && wr_mask_i[w]) begin
        age_mem_q[wr_addr_i][w] <= wr_entry_i;
      end
      if (rd_en_i) begin
        rd_row_q[w] <= age_mem_q[rd_addr_i][w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      valid_o[w]   = rd_row_q[w].valid;
      expired_o[w] = rd_row_q[w].valid && (rd_row_q[w].expiry <= now_i);
    end
  end

endmodule

// ----- design/bidirectional_flow_table_core.sv -----
// Bidirectional flow table.
// One command beat in on in_beat_i (valid/ready), one result beat out on
// out_beat_o (valid/ready). Commands: insert, bidirectional lookup, expiry sweep.
// Keys and expiry ticks live in two bucket-wide synchronous memories; each
// bucket row holds all ways, so an insert or lookup is a single row read and
// an insert at most a single masked write.
// Insert/lookup: when BUCKET_COUNT is a power of two, a row read on acceptance,
// then compare and write back, which waits for a free output register;
// otherwise a two-stage reciprocal-multiply remainder comes first to give the
// bucket hash.
// Sweep: one row read per cycle with the write back of the previous row
// overlapped on the expiry memory port.
// Reset: valid bits are cleared by a pass over the expiry memory, one row per
// cycle, during which in_ready_o stays low.
// A finished result sits in the output register while the next beat is
// accepted; a stalled receiver holds the block only when that next result is
// ready to be written.
module bidirectional_flow_table_core import bft_pkg::*; #(
  parameter int unsigned BUCKET_COUNT = DEF_BUCKET_COUNT,
  parameter int unsigned WAY_COUNT    = DEF_WAY_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned RW          = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned WW          = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned ENTRY_TOTAL = BUCKET_COUNT * WAY_COUNT;
  localparam int unsigned CW          = $clog2(ENTRY_TOTAL + 1);

  fsm_e state_q, state_d;

  in_beat_t  item_q;
  logic [RW-1:0] bucket_q;
  logic [RW:0]   row_q;
  logic [RW-1:0] wb_row_q;
  logic          pend_q;
  logic [CW-1:0] removed_q;
  logic [CW-1:0] flow_count_q;
  logic [CW-1:0] flow_next;
  logic          out_valid_q;
  out_beat_t     out_q;
  out_beat_t     res;

  logic accept, hash_start, hash_done, out_free, out_load, sweep_issue;
  logic [RW-1:0] hash_bucket;
  key_t in_key, item_key;

  logic          rd_en, key_rd_en;
  logic [RW-1:0] rd_addr;
  logic          key_wr_en, age_wr_en;
  logic [RW-1:0] age_wr_addr;
  logic [WAY_COUNT-1:0] key_wr_mask, age_wr_mask;
  age_t          age_wr_entry;

  logic [WAY_COUNT-1:0] key_match, age_valid, age_expired, hit_vec, free_vec, free_onehot;
  logic [WW-1:0] free_way, hit_way;
  logic [31:0]   free_idx, hit_idx, live_ext, removed_ext;

  assign in_key   = '{src_ip: in_beat_i.src_ip, dst_ip: in_beat_i.dst_ip,
                      sport: in_beat_i.sport, dport: in_beat_i.dport};
  assign item_key = '{src_ip: item_q.src_ip, dst_ip: item_q.dst_ip,
                      sport: item_q.sport, dport: item_q.dport};

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign hash_start  = accept && ((in_beat_i.cmd == CMD_INSERT) || (in_beat_i.cmd == CMD_LOOKUP));
  assign out_free    = !out_valid_q || out_ready_i;
  assign sweep_issue = (state_q == S_SWEEP) && (row_q < (RW+1)'(BUCKET_COUNT));

  bft_hash #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_key),
    .done_o  (hash_done),
    .bucket_o(hash_bucket)
  );

  bft_key_store #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .WAY_COUNT   (WAY_COUNT)
  ) u_key_store (
    .clk_i      (clk_i),
    .rd_en_i    (key_rd_en),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (key_wr_en),
    .wr_addr_i  (bucket_q),
    .wr_mask_i  (key_wr_mask),
    .wr_key_i   (item_key),
    .probe_key_i(item_key),
    .match_o    (key_match)
  );

  bft_age_store #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .WAY_COUNT   (WAY_COUNT)
  ) u_age_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (age_wr_en),
    .wr_addr_i (age_wr_addr),
    .wr_mask_i (age_wr_mask),
    .wr_entry_i(age_wr_entry),
    .now_i     (item_q.now_time),
    .valid_o   (age_valid),
    .expired_o (age_expired)
  );

  // first free and first hit way
  assign free_vec = ~age_valid;
  assign hit_vec  = age_valid & key_match;

  always_comb begin
    free_way    = '0;
    hit_way     = '0;
    free_onehot = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (free_vec[w]) begin
        free_way    = WW'(w);
        free_onehot = '0;
        free_onehot[w] = 1'b1;
      end
      if (hit_vec[w]) begin
        hit_way = WW'(w);
      end
    end
  end

  assign free_idx = 32'(bucket_q) * 32'(WAY_COUNT) + 32'(free_way);
  assign hit_idx  = 32'(bucket_q) * 32'(WAY_COUNT) + 32'(hit_way);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (row_q == (RW+1)'(BUCKET_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_beat_i.cmd)
            CMD_INSERT, CMD_LOOKUP: state_d = hash_done ? S_EXEC : S_HASH;
            CMD_SWEEP:              state_d = S_SWEEP;
            default:                state_d = S_RESP;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (!sweep_issue && pend_q) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory control and result
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = hash_bucket;
    key_wr_en    = 1'b0;
    key_wr_mask  = free_onehot;
    age_wr_en    = 1'b0;
    age_wr_addr  = bucket_q;
    age_wr_mask  = free_onehot;
    age_wr_entry = '{valid: 1'b1, expiry: item_q.expire_time};
    out_load     = 1'b0;
    flow_next    = flow_count_q;
    res          = '0;
    res.status   = STAT_OK;
    case (state_q)
      S_CLEAR: begin
        age_wr_en    = 1'b1;
        age_wr_addr  = row_q[RW-1:0];
        age_wr_mask  = '1;
        age_wr_entry = '{valid: 1'b0, expiry: 32'd0};
      end
      S_IDLE: begin
        rd_en = hash_start && hash_done;
      end
      S_HASH: begin
        rd_en = hash_done;
      end
      S_EXEC: begin
        out_load = out_free;
        if (item_q.cmd == CMD_INSERT) begin
          if (|free_vec) begin
            key_wr_en       = out_free;
            age_wr_en       = out_free;
            flow_next       = flow_count_q + CW'(1);
            res.entry_index = free_idx[7:0];
          end else begin
            res.status = STAT_FULL;
          end
        end else begin
          if (|hit_vec) begin
            res.found       = 1'b1;
            res.entry_index = hit_idx[7:0];
          end else begin
            res.status = STAT_MISS;
          end
        end
      end
      S_SWEEP: begin
        rd_en        = sweep_issue;
        rd_addr      = row_q[RW-1:0];
        age_wr_en    = pend_q;
        age_wr_addr  = wb_row_q;
        age_wr_mask  = age_expired;
        age_wr_entry = '{valid: 1'b0, expiry: item_q.now_time};
      end
      S_RESP: begin
        out_load  = out_free;
        flow_next = flow_count_q - removed_q;
      end
      default: ;
    endcase
    live_ext          = 32'(flow_next);
    removed_ext       = 32'(removed_q);
    res.live_count    = live_ext[8:0];
    res.removed_count = (state_q == S_RESP) ? removed_ext[8:0] : 9'd0;
  end

  assign key_rd_en = rd_en && (state_q != S_SWEEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      row_q        <= '0;
      pend_q       <= 1'b0;
      removed_q    <= '0;
      flow_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= sweep_issue;
      if ((state_q == S_CLEAR) || sweep_issue) begin
        row_q <= row_q + (RW+1)'(1);
      end else if (accept) begin
        row_q <= '0;
      end
      if (accept) begin
        removed_q <= '0;
      end else if ((state_q == S_SWEEP) && pend_q) begin
        removed_q <= removed_q + CW'($countones(age_expired));
      end
      if (out_load) begin
        flow_count_q <= flow_next;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_beat_i;
    end
    if (rd_en && (state_q != S_SWEEP)) begin
      bucket_q <= hash_bucket;
    end
    if (sweep_issue) begin
      wb_row_q <= row_q[RW-1:0];
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTH
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result written over an unaccepted beat");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (age_wr_en && rd_en) |-> (age_wr_addr != rd_addr))
    else $error("read and write of the same bucket row in one cycle");

  a_insert_one_way: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_wr_en |-> ($onehot(key_wr_mask) && age_wr_en))
    else $error("insert must write exactly one way in both stores");

  a_flow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flow_count_q <= CW'(ENTRY_TOTAL))
    else $error("live flow count above table size");

  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (state_q == S_RESP)) |=> (flow_count_q == $past(flow_count_q - removed_q)))
    else $error("flow count not reduced by removed entries");
`endif

endmodule

// ----- test/tb.sv -----
module tb;
  import bft_pkg::*;

  localparam int unsigned BUCKETS = DEF_BUCKET_COUNT;
  localparam int unsigned WAYS    = DEF_WAY_COUNT;
  localparam int unsigned ENTRIES = BUCKETS * WAYS;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          SETTLE_CYCLES = 200;

  typedef enum int {V_SAME, V_REVERSED, V_NEIGHBOR, V_PORT_SWAP} variant_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  bidirectional_flow_table_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat)
  );

  always #1 clk_i = ~clk_i;

  // predicted table contents
  key_t        pred_key[ENTRIES];
  logic [31:0] flow_expiry[ENTRIES];
  bit          flow_valid[ENTRIES];
  int          live_flows = 0;

  in_beat_t  beat_q[$];
  int        gap_q[$];
  out_beat_t expected_q[$];
  key_t      pool_q[$];

  int          mismatches = 0;
  int          cycles = 0;
  int          hold_req = 0;
  int          hold_seen;
  int          hold_left;
  int          stall_left;
  int          idle_left;
  int          dense_left = 0;
  bit          no_idle = 1'b0;
  logic [31:0] tick;

  function automatic int unsigned flow_bucket(in_beat_t b);
    logic [31:0] x;
    x = b.src_ip ^ b.dst_ip ^ {16'h0, b.sport} ^ {16'h0, b.dport};
    x ^= x >> 16;
    x ^= x >> 8;
    return x % BUCKETS;
  endfunction

  function automatic out_beat_t predict_flow(in_beat_t b);
    out_beat_t r;
    int        base;
    int        idx;
    int        removed;
    bit        hit;
    key_t      fwd;
    key_t      rev;
    r = '0;
    hit = 1'b0;
    removed = 0;
    base = flow_bucket(b) * WAYS;
    fwd = '{src_ip: b.src_ip, dst_ip: b.dst_ip, sport: b.sport, dport: b.dport};
    rev = '{src_ip: b.dst_ip, dst_ip: b.src_ip, sport: b.dport, dport: b.sport};
    case (b.cmd)
      CMD_INSERT: begin
        r.status = STAT_FULL;
        for (int w = 0; w < WAYS; w++) begin
          idx = base + w;
          if (!hit && !flow_valid[idx]) begin
            pred_key[idx] = fwd;
            flow_expiry[idx] = b.expire_time;
            flow_valid[idx] = 1'b1;
            live_flows++;
            r.entry_index = idx[7:0];
            r.status = STAT_OK;
            hit = 1'b1;
          end
        end
      end
      CMD_LOOKUP: begin
        r.status = STAT_MISS;
        for (int w = 0; w < WAYS; w++) begin
          idx = base + w;
          if (!hit && flow_valid[idx] && (pred_key[idx] == fwd || pred_key[idx] == rev)) begin
            r.found = 1'b1;
            r.entry_index = idx[7:0];
            r.status = STAT_OK;
            hit = 1'b1;
          end
        end
      end
      CMD_SWEEP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (flow_valid[i] && flow_expiry[i] <= b.now_time) begin
            flow_valid[i] = 1'b0;
            removed++;
          end
        end
        live_flows -= removed;
        r.removed_count = removed[8:0];
      end
      default: ;
    endcase
    r.live_count = live_flows[8:0];
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    logic     nv;
    in_beat_t nb;
    int       ng;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      idle_left <= 0;
    end else begin
      nv = in_valid;
      nb = in_beat;
      ng = idle_left;
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_flow(in_beat));
        nv = 1'b0;
      end
      if (!nv) begin
        if (ng > 0) begin
          ng--;
        end else if (beat_q.size() > 0) begin
          nb = beat_q.pop_front();
          ng = gap_q.pop_front();
          nv = 1'b1;
        end
      end
      in_valid <= nv;
      in_beat <= nb;
      idle_left <= ng;
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    logic rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
      stall_left <= 0;
    end else begin
      rdy = 1'b0;
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        rdy = 1'b1;
      end else begin
        stall_left <= idle_len();
      end
      out_ready <= rdy;
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %p", $time, out_beat);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("found", want.found, out_beat.found);
        check_field("entry_index", want.entry_index, out_beat.entry_index);
        check_field("status", want.status, out_beat.status);
        check_field("removed_count", want.removed_count, out_beat.removed_count);
        check_field("live_count", want.live_count, out_beat.live_count);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic key_t fresh_key();
    key_t k;
    k.src_ip = $urandom;
    k.dst_ip = $urandom;
    k.sport = 16'($urandom_range(0, 65535));
    k.dport = 16'($urandom_range(0, 65535));
    return k;
  endfunction

  function automatic key_t variant_of(key_t k, variant_e how);
    key_t        v;
    logic [31:0] m;
    v = k;
    case (how)
      V_REVERSED: v = '{src_ip: k.dst_ip, dst_ip: k.src_ip,
                        sport: k.dport, dport: k.sport};
      V_NEIGHBOR: begin
        m = $urandom;
        v.src_ip = k.src_ip ^ m;
        v.dst_ip = k.dst_ip ^ m;
      end
      V_PORT_SWAP: begin
        v.sport = k.dport;
        v.dport = k.sport;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic key_t pool_pick();
    if (pool_q.size() == 0) return fresh_key();
    return pool_q[$urandom_range(0, pool_q.size() - 1)];
  endfunction

  task automatic send(logic [1:0] op, key_t k, logic [31:0] exp_t, logic [31:0] now_t);
    in_beat_t b;
    int       g;
    b.cmd = op;
    b.src_ip = k.src_ip;
    b.dst_ip = k.dst_ip;
    b.sport = k.sport;
    b.dport = k.dport;
    b.expire_time = exp_t;
    b.now_time = now_t;
    g = (no_idle || dense_left > 0) ? 0 : idle_len();
    if (dense_left > 0) dense_left--;
    beat_q.push_back(b);
    gap_q.push_back(g);
    if (op == CMD_INSERT) begin
      pool_q.push_back(k);
      if (pool_q.size() > 48) void'(pool_q.pop_front());
    end
  endtask

  task automatic send_random(int life, int sweep_pct, int ins_pct);
    int          r;
    int          pick;
    key_t        k;
    logic [31:0] e;
    r = $urandom_range(0, 99);
    if (r < sweep_pct) begin
      send(CMD_SWEEP, fresh_key(), $urandom, ($urandom_range(0, 19) == 0) ? $urandom : tick);
    end else if (r == 99) begin
      send(CMD_UNUSED, fresh_key(), $urandom, $urandom);
    end else if (r < sweep_pct + ins_pct) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) k = fresh_key();
      else if (pick < 7) k = variant_of(pool_pick(), (pick == 5) ? V_SAME : V_REVERSED);
      else if (pick < 9) k = variant_of(pool_pick(), V_NEIGHBOR);
      else k = variant_of(pool_pick(), V_PORT_SWAP);
      e = ($urandom_range(0, 29) == 0) ? $urandom : tick + $urandom_range(0, life);
      send(CMD_INSERT, k, e, $urandom);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 2) k = fresh_key();
      else if (pick < 5) k = pool_pick();
      else if (pick < 8) k = variant_of(pool_pick(), V_REVERSED);
      else if (pick < 9) k = variant_of(pool_pick(), V_NEIGHBOR);
      else k = variant_of(pool_pick(), V_PORT_SWAP);
      send(CMD_LOOKUP, k, $urandom, $urandom);
    end
    tick += $urandom_range(0, 40);
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    key_t kz;
    key_t ko;
    key_t kk;
    key_t kf;
    int   life_tab[4];
    int   sweep_tab[4];
    int   ins_tab[4];
    life_tab = '{400, 1 << 22, 2000, 300};
    sweep_tab = '{4, 1, 3, 6};
    ins_tab = '{45, 80, 45, 45};
    tick = $urandom_range(0, 1 << 30);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    kz = '0;
    ko = '1;
    kk = fresh_key();
    send(CMD_LOOKUP, kz, '0, '0);
    send(CMD_INSERT, kz, '0, '1);
    send(CMD_INSERT, ko, '1, '0);
    send(CMD_LOOKUP, ko, '0, '0);
    send(CMD_LOOKUP, kz, '1, '1);
    send(CMD_INSERT, kk, tick + 100, $urandom);
    send(CMD_LOOKUP, variant_of(kk, V_REVERSED), $urandom, $urandom);
    send(CMD_LOOKUP, variant_of(kk, V_PORT_SWAP), $urandom, $urandom);
    send(CMD_LOOKUP, variant_of(kk, V_NEIGHBOR), $urandom, $urandom);
    repeat (4) send(CMD_INSERT, variant_of(kk, V_REVERSED), tick + 200, $urandom);
    send(CMD_LOOKUP, kk, $urandom, $urandom);
    send(CMD_UNUSED, fresh_key(), $urandom, $urandom);
    send(CMD_SWEEP, fresh_key(), $urandom, '0);
    send(CMD_LOOKUP, kz, $urandom, $urandom);
    send(CMD_SWEEP, fresh_key(), $urandom, '1);
    send(CMD_LOOKUP, kk, $urandom, $urandom);
    send(CMD_SWEEP, fresh_key(), $urandom, $urandom);
    drain();

    for (int p = 0; p < 4; p++) begin
      no_idle = (p == 2);
      if (p == 3) begin
        hold_req++;
        dense_left = 80;
      end
      repeat (400) send_random(life_tab[p], sweep_tab[p], ins_tab[p]);
      if (p == 1) begin
        // fill every way of every bucket, then expire the whole table
        for (int b = 0; b < BUCKETS; b++) begin
          for (int w = 0; w < WAYS; w++) begin
            kf.dst_ip = $urandom;
            kf.src_ip = kf.dst_ip ^ b;
            kf.sport = 16'($urandom_range(0, 65535));
            kf.dport = kf.sport;
            send(CMD_INSERT, kf, tick + life_tab[p], $urandom);
          end
        end
        send(CMD_LOOKUP, pool_pick(), $urandom, $urandom);
        send(CMD_SWEEP, fresh_key(), $urandom, '1);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d result beats expected, none arrived", $time, expected_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bft_pkg.sv
design/bft_hash.sv
design/bft_key_store.sv
design/bft_age_store.sv
design/bidirectional_flow_table_core.sv
test/tb.sv
